// ----- hw/rtl/pee_pkg.sv -----
// Types and constants shared by the postfix evaluator files.
package pee_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0]  t_symbol;
    typedef logic [2:0]  t_state;
    typedef logic [1:0]  t_op;
    typedef logic [2:0]  t_flags;

    localparam t_symbol SYM_END = 8'd0;
    localparam t_symbol SYM_ADD = 8'd43;
    localparam t_symbol SYM_SUB = 8'd45;
    localparam t_symbol SYM_MUL = 8'd42;
    localparam t_symbol SYM_DIV = 8'd47;

    localparam t_word DIGIT_BASE  = 32'd48;
    localparam t_word EMPTY_VALUE = 32'hFFFF_FFFF;

    localparam t_op OP_ADD = 2'd0;
    localparam t_op OP_SUB = 2'd1;
    localparam t_op OP_MUL = 2'd2;
    localparam t_op OP_DIV = 2'd3;

    localparam int FLAG_UNDER = 0;
    localparam int FLAG_OVER  = 1;
    localparam int FLAG_DIVZ  = 2;

    localparam t_state S_IDLE    = 3'd0;
    localparam t_state S_POP_L   = 3'd1;
    localparam t_state S_EXEC    = 3'd2;
    localparam t_state S_DIV     = 3'd3;
    localparam t_state S_DIV_FIX = 3'd4;
    localparam t_state S_PUSH    = 3'd5;
    localparam t_state S_TERM    = 3'd6;

endpackage

// ----- hw/rtl/pee_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ----- hw/rtl/postfix_expression_evaluator_core.sv -----
// Postfix expression evaluator: operand stack in RAM, sequencer and shared arithmetic unit.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------------
//   input    | i_in_valid / o_in_stall    | i_in_symbol[7:0]
//   output   | o_out_valid / i_out_stall  | o_value[31:0], o_underflow, o_overflow,
//            |                            | o_divide_by_zero
//
// Operand bytes are pushed straight from idle. A terminator pops the top of stack, then waits
// in S_TERM for the output register. + - * make two stack reads through the RAM's registered
// read port, execute and push. Division sets up in execute; with a zero divisor it pushes zero,
// else the shared restoring divider retires one quotient bit a cycle, then fixes sign and pushes.
// Synchronous active-low reset empties the stack and clears the flags and output valid.
// A held result does not block operand and operator transactions; a terminator waits for it.
module postfix_expression_evaluator_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pee_pkg::t_symbol    i_in_symbol,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_value,
    output logic                o_underflow,
    output logic                o_overflow,
    output logic                o_divide_by_zero
);

    import pee_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    t_flags         r_flags, n_flags;
    logic           r_rd_pend, n_rd_pend;
    logic           r_out_valid, n_out_valid;
    t_op            r_op, n_op;
    t_word          r_rhs, n_rhs;
    t_word          r_quo, n_quo;
    t_word          r_rem, n_rem;
    t_word          r_res, n_res;
    logic           r_neg, n_neg;
    logic [4:0]     r_div_cnt, n_div_cnt;
    t_word          r_value, n_value;
    t_flags         r_out_flags, n_out_flags;

    logic           w_accept;
    logic           w_is_end;
    logic           w_is_op;
    logic           w_can_pop;
    logic           w_full;
    logic [CW-1:0]  w_count_dec;
    t_word          w_rd_data;
    t_word          w_popped;
    t_word          w_left_mag;
    t_word          w_right_mag;
    logic [32:0]    w_rem_sh;
    logic [32:0]    w_diff;
    logic           w_wr_en;
    logic [AW-1:0]  w_wr_addr;
    t_word          w_wr_data;
    logic           w_rd_en;

    pee_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_count_dec[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign o_in_stall       = (r_state != S_IDLE);
    assign w_accept         = i_in_valid && !o_in_stall;
    assign w_is_end         = (i_in_symbol == SYM_END);
    assign w_is_op          = (i_in_symbol == SYM_ADD) || (i_in_symbol == SYM_SUB) ||
                              (i_in_symbol == SYM_MUL) || (i_in_symbol == SYM_DIV);
    assign w_can_pop        = (r_count != '0);
    assign w_full           = (r_count == CW'(STACK_DEPTH));
    assign w_count_dec      = r_count - CW'(1);
    assign w_wr_addr        = r_count[AW-1:0];
    assign w_popped         = r_rd_pend ? w_rd_data : EMPTY_VALUE;
    assign w_left_mag       = w_popped[31] ? (32'd0 - w_popped) : w_popped;
    assign w_right_mag      = r_rhs[31] ? (32'd0 - r_rhs) : r_rhs;
    assign w_rem_sh         = {r_rem, r_quo[31]};
    assign w_diff           = w_rem_sh - {1'b0, r_rhs};

    assign o_out_valid      = r_out_valid;
    assign o_value          = signed'(r_value);
    assign o_underflow      = r_out_flags[FLAG_UNDER];
    assign o_overflow       = r_out_flags[FLAG_OVER];
    assign o_divide_by_zero = r_out_flags[FLAG_DIVZ];

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_flags     = r_flags;
        n_rd_pend   = r_rd_pend;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_rhs       = r_rhs;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_res       = r_res;
        n_neg       = r_neg;
        n_div_cnt   = r_div_cnt;
        n_value     = r_value;
        n_out_flags = r_out_flags;
        w_wr_en     = 1'b0;
        w_wr_data   = r_res;
        w_rd_en     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_is_end || w_is_op) begin
                        if (w_can_pop) begin
                            w_rd_en   = 1'b1;
                            n_count   = w_count_dec;
                            n_rd_pend = 1'b1;
                        end else begin
                            n_rd_pend            = 1'b0;
                            n_flags[FLAG_UNDER]  = 1'b1;
                        end
                        if (w_is_end) begin
                            n_state = S_TERM;
                        end else begin
                            n_state = S_POP_L;
                            case (i_in_symbol)
                                SYM_ADD: n_op = OP_ADD;
                                SYM_SUB: n_op = OP_SUB;
                                SYM_MUL: n_op = OP_MUL;
                                default: n_op = OP_DIV;
                            endcase
                        end
                    end else begin
                        w_wr_data = t_word'(i_in_symbol) - DIGIT_BASE;
                        if (!w_full) begin
                            w_wr_en = 1'b1;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_flags[FLAG_OVER] = 1'b1;
                        end
                    end
                end
            end
            S_POP_L: begin
                n_rhs = w_popped;
                if (w_can_pop) begin
                    w_rd_en   = 1'b1;
                    n_count   = w_count_dec;
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend           = 1'b0;
                    n_flags[FLAG_UNDER] = 1'b1;
                end
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_PUSH;
                case (r_op)
                    OP_ADD: n_res = w_popped + r_rhs;
                    OP_SUB: n_res = w_popped - r_rhs;
                    OP_MUL: n_res = w_popped * r_rhs;
                    default: begin
                        if (r_rhs == '0) begin
                            n_res              = '0;
                            n_flags[FLAG_DIVZ] = 1'b1;
                        end else begin
                            n_quo     = w_left_mag;
                            n_rem     = '0;
                            n_rhs     = w_right_mag;
                            n_neg     = w_popped[31] ^ r_rhs[31];
                            n_div_cnt = 5'd31;
                            n_state   = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (!w_diff[32]) begin
                    n_rem = w_diff[31:0];
                    n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[31:0];
                    n_quo = {r_quo[30:0], 1'b0};
                end
                n_div_cnt = r_div_cnt - 5'd1;
                if (r_div_cnt == '0) begin
                    n_state = S_DIV_FIX;
                end
            end
            S_DIV_FIX: begin
                n_res   = r_neg ? (32'd0 - r_quo) : r_quo;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!w_full) begin
                    w_wr_en = 1'b1;
                    n_count = r_count + CW'(1);
                end else begin
                    n_flags[FLAG_OVER] = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_TERM: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_value     = w_popped;
                    n_out_flags = r_flags;
                    n_flags     = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_flags     <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_flags     <= n_flags;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_rhs       <= n_rhs;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_res       <= n_res;
        r_neg       <= n_neg;
        r_div_cnt   <= n_div_cnt;
        r_value     <= n_value;
        r_out_flags <= n_out_flags;
    end

endmodule

// ----- bench/tb_postfix_expression_evaluator_core.sv -----
// Self-checking testbench for the postfix expression evaluator core.
module tb_postfix_expression_evaluator_core;
    import pee_pkg::*;

    localparam int DEPTH         = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 60;
    localparam int SCRIPT_ROWS   = 31;

    localparam t_symbol SYM_NEG_TWO  = 8'd46;
    localparam t_symbol SYM_DIGIT_0  = 8'd48;
    localparam t_symbol SYM_DIGIT_1  = 8'd49;
    localparam t_symbol SYM_DIGIT_8  = 8'd56;
    localparam t_symbol SYM_PUSH_128 = 8'd176;
    localparam t_symbol SYM_TOP      = 8'd255;

    typedef struct packed {
        t_word value;
        logic  underflow;
        logic  overflow;
        logic  divide_by_zero;
    } outcome_t;

    typedef struct packed {
        t_symbol  symbol;
        logic     typed;
        outcome_t outcome;
    } script_row_t;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    logic           o_in_stall;
    t_symbol        i_in_symbol = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    logic signed [31:0] o_value;
    logic           o_underflow;
    logic           o_overflow;
    logic           o_divide_by_zero;

    t_word       model_stack [DEPTH];
    int unsigned model_depth = 0;
    logic        seen_underflow = 1'b0;
    logic        seen_overflow = 1'b0;
    logic        seen_div_zero = 1'b0;

    outcome_t    awaited_outcomes [$];
    script_row_t script [SCRIPT_ROWS];
    int          mismatches = 0;
    int          sent_items = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    postfix_expression_evaluator_core #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_symbol      (i_in_symbol),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_value          (o_value),
        .o_underflow      (o_underflow),
        .o_overflow       (o_overflow),
        .o_divide_by_zero (o_divide_by_zero)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit is_operator(input t_symbol s);
        return s == SYM_ADD || s == SYM_SUB || s == SYM_MUL || s == SYM_DIV;
    endfunction

    function automatic t_word take_operand();
        if (model_depth == 0) begin
            seen_underflow = 1'b1;
            return EMPTY_VALUE;
        end
        model_depth--;
        return model_stack[model_depth];
    endfunction

    function automatic void place_operand(input t_word v);
        if (model_depth >= DEPTH) begin
            seen_overflow = 1'b1;
        end else begin
            model_stack[model_depth] = v;
            model_depth++;
        end
    endfunction

    function automatic t_word truncated_quotient(input t_word lhs, input t_word rhs);
        logic  neg_l;
        logic  neg_r;
        t_word mag_l;
        t_word mag_r;
        t_word q;
        if (rhs == '0) begin
            seen_div_zero = 1'b1;
            return '0;
        end
        neg_l = lhs[31];
        neg_r = rhs[31];
        mag_l = neg_l ? -lhs : lhs;
        mag_r = neg_r ? -rhs : rhs;
        q = mag_l / mag_r;
        return (neg_l != neg_r) ? -q : q;
    endfunction

    function automatic bit evaluate_symbol(input t_symbol s, output outcome_t o);
        t_word lhs;
        t_word rhs;
        t_word res;
        o = '0;
        if (s == SYM_END) begin
            o.value = take_operand();
            o.underflow = seen_underflow;
            o.overflow = seen_overflow;
            o.divide_by_zero = seen_div_zero;
            seen_underflow = 1'b0;
            seen_overflow = 1'b0;
            seen_div_zero = 1'b0;
            return 1'b1;
        end
        if (!is_operator(s)) begin
            place_operand({24'd0, s} - DIGIT_BASE);
            return 1'b0;
        end
        rhs = take_operand();
        lhs = take_operand();
        case (s)
            SYM_ADD: res = lhs + rhs;
            SYM_SUB: res = lhs - rhs;
            SYM_MUL: res = lhs * rhs;
            default: res = truncated_quotient(lhs, rhs);
        endcase
        place_operand(res);
        return 1'b0;
    endfunction

    function automatic script_row_t plain(input t_symbol s);
        script_row_t r;
        r = '0;
        r.symbol = s;
        return r;
    endfunction

    function automatic script_row_t with_result(input t_symbol s, input t_word v,
                                                input logic uf, input logic of,
                                                input logic dz);
        script_row_t r;
        r.symbol = s;
        r.typed = 1'b1;
        r.outcome.value = v;
        r.outcome.underflow = uf;
        r.outcome.overflow = of;
        r.outcome.divide_by_zero = dz;
        return r;
    endfunction

    function automatic t_symbol any_operator();
        case ($urandom_range(3))
            0:       return SYM_ADD;
            1:       return SYM_SUB;
            2:       return SYM_MUL;
            default: return SYM_DIV;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch on %s: got %h, want %h", what, got, want);
        mismatches++;
    endtask

    task automatic check_outcome();
        outcome_t want;
        if (awaited_outcomes.size() == 0) begin
            note_mismatch("result with nothing awaited", o_value, '0);
            return;
        end
        want = awaited_outcomes.pop_front();
        if (o_value !== want.value)
            note_mismatch("value", o_value, want.value);
        if (o_underflow !== want.underflow)
            note_mismatch("underflow", 32'(o_underflow), 32'(want.underflow));
        if (o_overflow !== want.overflow)
            note_mismatch("overflow", 32'(o_overflow), 32'(want.overflow));
        if (o_divide_by_zero !== want.divide_by_zero)
            note_mismatch("divide_by_zero", 32'(o_divide_by_zero),
                          32'(want.divide_by_zero));
    endtask

    // receiving side: check, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_outcome();
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_symbol(input t_symbol s, input logic typed,
                               input outcome_t typed_outcome);
        outcome_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_symbol <= s;
        do @(posedge i_clk); while (o_in_stall);
        sent_items++;
        if (evaluate_symbol(s, predicted))
            awaited_outcomes.push_back(typed ? typed_outcome : predicted);
    endtask

    task automatic offer(input t_symbol s);
        send_symbol(s, 1'b0, '0);
    endtask

    task automatic offer_operand();
        t_symbol s;
        if ($urandom_range(9) < 7) begin
            s = SYM_DIGIT_0 + t_symbol'($urandom_range(9));
        end else begin
            do s = t_symbol'($urandom_range(1, 255)); while (is_operator(s));
        end
        offer(s);
    endtask

    // well-formed expression over its own operands, then the terminator
    task automatic offer_expression();
        int operands_left;
        int depth_now;
        operands_left = $urandom_range(1, 7);
        depth_now = 0;
        while (operands_left > 0 || depth_now > 1) begin
            if (operands_left > 0 && (depth_now < 2 || $urandom_range(1) == 1)) begin
                offer_operand();
                operands_left--;
                depth_now++;
            end else begin
                offer(any_operator());
                depth_now--;
            end
        end
        offer(SYM_END);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct,
                              input int item_target);
        int kind;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent_items < item_target) begin
            kind = $urandom_range(99);
            if (kind < 75) begin
                offer_expression();
            end else if (kind < 85) begin
                offer(t_symbol'($urandom_range(255)));
            end else if (kind < 93) begin
                repeat ($urandom_range(14, 20)) offer_operand();
                offer(SYM_END);
            end else begin
                repeat ($urandom_range(2, 18)) offer(any_operator());
                offer(SYM_END);
            end
        end
        drain_results();
    endtask

    initial begin
        script = '{
            with_result(SYM_END, EMPTY_VALUE, 1'b1, 1'b0, 1'b0),
            plain(SYM_PUSH_128), plain(SYM_PUSH_128), plain(SYM_PUSH_128),
            plain(SYM_PUSH_128), plain(SYM_PUSH_128), plain(SYM_PUSH_128),
            plain(SYM_PUSH_128), plain(SYM_PUSH_128), plain(SYM_PUSH_128),
            plain(SYM_PUSH_128), plain(SYM_PUSH_128), plain(SYM_PUSH_128),
            plain(SYM_PUSH_128), plain(SYM_PUSH_128), plain(SYM_PUSH_128),
            plain(SYM_PUSH_128),
            plain(SYM_TOP), plain(SYM_SUB), plain(SYM_DIV),
            with_result(SYM_END, 32'h0000_0000, 1'b0, 1'b1, 1'b1),
            plain(SYM_MUL), plain(SYM_MUL), plain(SYM_MUL),
            plain(SYM_DIGIT_8), plain(SYM_MUL),
            plain(SYM_NEG_TWO), plain(SYM_DIGIT_1), plain(SYM_ADD),
            plain(SYM_DIV),
            with_result(SYM_END, 32'h8000_0000, 1'b0, 1'b0, 1'b0)
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int row = 0; row < SCRIPT_ROWS; row++)
            send_symbol(script[row].symbol, script[row].typed, script[row].outcome);
        drain_results();

        run_random(0, 0, 450);
        run_random(65, 0, 850);
        // hold the output long enough for the input to back up
        hold_req++;
        run_random(0, 65, 1300);
        run_random(19, 19, 1720);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pee_pkg.sv
hw/rtl/pee_ram.sv
hw/rtl/postfix_expression_evaluator_core.sv
bench/tb_postfix_expression_evaluator_core.sv
